>>> rtl/core/page_table_walk_and_map_defines.svh
// Assertion macros used by the checker file.
`ifndef PAGE_TABLE_WALK_AND_MAP_DEFINES_SVH
`define PAGE_TABLE_WALK_AND_MAP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptw check failed");

// Next-cycle implication, held off while reset is asserted.
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptw check failed");

`endif

>>> rtl/core/ptw_pkg.sv
package ptw_pkg;

    localparam int unsigned ENTRIES_PER_TABLE = 512;
    localparam int unsigned PAGE_BYTES        = 4096;

    localparam int unsigned IDX_W   = 9;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned VA_W    = 48;
    localparam int unsigned PA_W    = 52;
    localparam int unsigned ENTRY_W = 64;

    localparam logic [ENTRY_W-1:0] ENTRY_MASK = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [ENTRY_W-1:0] PAGE_STEP  = 64'(PAGE_BYTES);
    localparam logic [ENTRY_W-1:0] PTE_FLAGS  = 64'd7;
    localparam logic [CNT_W:0]     FIT_LIMIT  = 11'(ENTRIES_PER_TABLE);

    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

    // request operation codes
    localparam logic [2:0] OP_LOOKUP     = 3'd0;
    localparam logic [2:0] OP_MAP        = 3'd1;
    localparam logic [2:0] OP_READ_DATA  = 3'd2;
    localparam logic [2:0] OP_GRANT      = 3'd3;
    localparam logic [2:0] OP_WRITE_DONE = 3'd4;

    // result kind codes
    localparam logic [2:0] KIND_READ        = 3'd0;
    localparam logic [2:0] KIND_WRITE       = 3'd1;
    localparam logic [2:0] KIND_ALLOC       = 3'd2;
    localparam logic [2:0] KIND_LOOKUP_DONE = 3'd3;
    localparam logic [2:0] KIND_MAP_DONE    = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    root_base;
        logic [PA_W-1:0]    first_frame;
        logic [CNT_W-1:0]   page_count;
        logic [ENTRY_W-1:0] read_data;
        logic [PA_W-1:0]    granted_page;
    } t_req;

    typedef struct packed {
        logic [2:0]         kind;
        logic [ENTRY_W-1:0] mem_address;
        logic [ENTRY_W-1:0] write_data;
        logic [ENTRY_W-1:0] leaf_entry;
        logic               found;
    } t_rsp;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_slot;

    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_rsp_slot;

    // 9-bit table index of a virtual address at a walk level
    function automatic logic [IDX_W-1:0] idx_of(logic [VA_W-1:0] va, logic [LEVEL_W-1:0] lv);
        logic [IDX_W-1:0] idx;
        case (lv)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/core/ptw_in_stage.sv
module ptw_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ptw_pkg::t_req       i_req,
    input  logic                i_out_free,
    output ptw_pkg::t_req_slot  o_slot
);

    logic          r_valid;
    ptw_pkg::t_req r_req;
    logic          fire;
    logic          load;

    assign fire    = r_valid && i_out_free;
    assign o_stall = r_valid && !i_out_free;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= i_req;
        end
    end

    assign o_slot.valid = fire;
    assign o_slot.req   = r_req;

endmodule

>>> rtl/core/ptw_walk_core.sv
module ptw_walk_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptw_pkg::t_req_slot i_slot,
    output ptw_pkg::t_rsp_slot o_slot
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_READ  = 5'b00010,
        PH_GRANT = 5'b00100,
        PH_LINK  = 5'b01000,
        PH_LEAF  = 5'b10000
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [ptw_pkg::LEVEL_W-1:0]   r_level, n_level;
    logic [ptw_pkg::VA_W-1:0]      r_held_vaddr, n_held_vaddr;
    logic [ptw_pkg::ENTRY_W-1:0]   r_table_base, n_table_base;
    logic [ptw_pkg::ENTRY_W-1:0]   r_next_frame, n_next_frame;
    logic [ptw_pkg::CNT_W-1:0]     r_pages_left, n_pages_left;
    logic [ptw_pkg::CNT_W-1:0]     r_leaf_cursor, n_leaf_cursor;
    logic                          r_mapping, n_mapping;

    ptw_pkg::t_req                 req;
    logic [2:0]                    op;
    logic                          is_start, is_read, is_grant, is_link, is_leaf;
    logic [ptw_pkg::ENTRY_W-1:0]   entry_masked;
    logic                          present;
    logic [ptw_pkg::LEVEL_W-1:0]   level_up;
    logic                          read_to_leaf, link_to_leaf, leaf_start;
    logic [ptw_pkg::IDX_W-1:0]     leaf_off;
    logic [ptw_pkg::CNT_W:0]       fit_sum;
    logic                          fits;
    logic [ptw_pkg::ENTRY_W-1:0]   leaf_base;
    logic [ptw_pkg::CNT_W-1:0]     leaf_cur;
    logic [ptw_pkg::ENTRY_W-1:0]   leaf_addr;
    logic [ptw_pkg::ENTRY_W-1:0]   walk_base;
    logic [ptw_pkg::IDX_W-1:0]     walk_idx;
    logic [ptw_pkg::ENTRY_W-1:0]   walk_addr;
    ptw_pkg::t_rsp                 rsp;
    logic                          rsp_valid;

    assign req = i_slot.req;
    assign op  = req.operation;

    assign is_start = (op == ptw_pkg::OP_LOOKUP || op == ptw_pkg::OP_MAP) && r_phase == PH_IDLE;
    assign is_read  = op == ptw_pkg::OP_READ_DATA  && r_phase == PH_READ;
    assign is_grant = op == ptw_pkg::OP_GRANT      && r_phase == PH_GRANT;
    assign is_link  = op == ptw_pkg::OP_WRITE_DONE && r_phase == PH_LINK;
    assign is_leaf  = op == ptw_pkg::OP_WRITE_DONE && r_phase == PH_LEAF;

    assign entry_masked = req.read_data & ptw_pkg::ENTRY_MASK;
    assign present      = req.read_data[0];
    assign level_up     = r_level + 2'd1;

    // map walk reaches the leaf table either via a present level 2 entry
    // or via the acknowledge of the last table link
    assign read_to_leaf = is_read && r_level != ptw_pkg::LEVEL_LEAF && present && r_mapping
                          && level_up == ptw_pkg::LEVEL_LEAF;
    assign link_to_leaf = is_link && r_level == ptw_pkg::LEVEL_LEAF;
    assign leaf_start   = read_to_leaf || link_to_leaf;

    assign leaf_off  = ptw_pkg::idx_of(r_held_vaddr, ptw_pkg::LEVEL_LEAF);
    assign fit_sum   = {2'b00, leaf_off} + {1'b0, r_pages_left};
    assign fits      = fit_sum <= ptw_pkg::FIT_LIMIT;
    assign leaf_base = read_to_leaf ? entry_masked : r_table_base;
    assign leaf_cur  = leaf_start ? {1'b0, leaf_off} : r_leaf_cursor;
    assign leaf_addr = leaf_base + {51'd0, leaf_cur, 3'b000};

    // shared walk entry address adder
    always_comb begin
        walk_base = r_table_base;
        walk_idx  = ptw_pkg::idx_of(r_held_vaddr, r_level);
        if (is_start) begin
            walk_base = {12'd0, req.root_base};
            walk_idx  = ptw_pkg::idx_of(req.virt_addr, 2'd0);
        end else if (is_read) begin
            walk_base = entry_masked;
            walk_idx  = ptw_pkg::idx_of(r_held_vaddr, level_up);
        end
    end
    assign walk_addr = walk_base + {52'd0, walk_idx, 3'b000};

    always_comb begin
        n_phase       = r_phase;
        n_level       = r_level;
        n_held_vaddr  = r_held_vaddr;
        n_table_base  = r_table_base;
        n_next_frame  = r_next_frame;
        n_pages_left  = r_pages_left;
        n_leaf_cursor = r_leaf_cursor;
        n_mapping     = r_mapping;
        rsp           = '0;
        rsp_valid     = 1'b0;

        if (is_start) begin
            n_held_vaddr    = req.virt_addr;
            n_table_base    = {12'd0, req.root_base};
            n_level         = 2'd0;
            n_mapping       = op == ptw_pkg::OP_MAP;
            if (op == ptw_pkg::OP_MAP) begin
                n_next_frame = {12'd0, req.first_frame};
                n_pages_left = req.page_count;
            end
            n_phase         = PH_READ;
            rsp.kind        = ptw_pkg::KIND_READ;
            rsp.mem_address = walk_addr;
            rsp_valid       = 1'b1;
        end else if (is_read) begin
            rsp_valid = 1'b1;
            if (r_level == ptw_pkg::LEVEL_LEAF) begin
                n_phase        = PH_IDLE;
                rsp.kind       = ptw_pkg::KIND_LOOKUP_DONE;
                rsp.leaf_entry = req.read_data;
                rsp.found      = 1'b1;
            end else if (present) begin
                n_table_base = entry_masked;
                n_level      = level_up;
                if (!read_to_leaf) begin
                    rsp.kind        = ptw_pkg::KIND_READ;
                    rsp.mem_address = walk_addr;
                end
            end else if (!r_mapping) begin
                n_phase  = PH_IDLE;
                rsp.kind = ptw_pkg::KIND_LOOKUP_DONE;
            end else begin
                n_phase  = PH_GRANT;
                rsp.kind = ptw_pkg::KIND_ALLOC;
            end
        end else if (is_grant) begin
            rsp_valid       = 1'b1;
            rsp.kind        = ptw_pkg::KIND_WRITE;
            rsp.mem_address = walk_addr;
            rsp.write_data  = {12'd0, req.granted_page} | ptw_pkg::PTE_FLAGS;
            n_table_base    = {12'd0, req.granted_page};
            n_level         = level_up;
            n_phase         = PH_LINK;
        end else if (is_link && !link_to_leaf) begin
            rsp_valid = 1'b1;
            rsp.kind  = ptw_pkg::KIND_ALLOC;
            n_phase   = PH_GRANT;
        end

        // leaf write sequence: fit check on entry, then one write per ack
        if (leaf_start || is_leaf) begin
            rsp       = '0;
            rsp_valid = 1'b1;
            if (leaf_start && !fits) begin
                n_phase   = PH_IDLE;
                rsp.kind  = ptw_pkg::KIND_MAP_DONE;
            end else if (r_pages_left == '0) begin
                n_phase   = PH_IDLE;
                rsp.kind  = ptw_pkg::KIND_MAP_DONE;
                rsp.found = 1'b1;
            end else begin
                rsp.kind        = ptw_pkg::KIND_WRITE;
                rsp.mem_address = leaf_addr;
                rsp.write_data  = r_next_frame | ptw_pkg::PTE_FLAGS;
                n_next_frame    = r_next_frame + ptw_pkg::PAGE_STEP;
                n_leaf_cursor   = leaf_cur + 10'd1;
                n_pages_left    = r_pages_left - 10'd1;
                n_phase         = PH_LEAF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_level       <= '0;
            r_held_vaddr  <= '0;
            r_table_base  <= '0;
            r_next_frame  <= '0;
            r_pages_left  <= '0;
            r_leaf_cursor <= '0;
            r_mapping     <= 1'b0;
        end else if (i_slot.valid) begin
            r_phase       <= n_phase;
            r_level       <= n_level;
            r_held_vaddr  <= n_held_vaddr;
            r_table_base  <= n_table_base;
            r_next_frame  <= n_next_frame;
            r_pages_left  <= n_pages_left;
            r_leaf_cursor <= n_leaf_cursor;
            r_mapping     <= n_mapping;
        end
    end

    assign o_slot.valid = i_slot.valid && rsp_valid;
    assign o_slot.rsp   = rsp;

endmodule

>>> rtl/core/ptw_out_stage.sv
module ptw_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptw_pkg::t_rsp_slot i_slot,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_stall,
    output ptw_pkg::t_rsp      o_rsp
);

    logic          r_valid;
    ptw_pkg::t_rsp r_rsp;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_slot.valid) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_slot.valid) begin
            r_rsp <= i_slot.rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> rtl/core/page_table_walk_and_map.sv
// Four-level page-table walker that drives an external memory one access at a time.
// Request channel (i_in_valid / o_in_stall / i_in_req): lookup and map requests, plus
//   the memory side's replies fed back in (read data, page granted, write done).
// Result channel (o_out_valid / i_out_stall / o_out_rsp): read, write and allocate
//   requests toward memory and the page allocator, then lookup done or map done.
// Each accepted request is registered, evaluated in one pass against the walk state
// once the output register is free, and gives at most one result, which is loaded into
// the output register. One request can be accepted every cycle while o_in_stall is low;
// a walk's total time is set by how fast the memory and allocator answer the results
// it issues.
// Requests that do not fit the current walk phase are dropped without a result.
// Reset (synchronous, active low) empties both registers and returns the walk to idle.
// While the receiver stalls, the result is held; one more request can be taken into
// the input register, after which o_in_stall rises until the result is taken.
module page_table_walk_and_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ptw_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ptw_pkg::t_rsp o_out_rsp
);

    ptw_pkg::t_req_slot req_slot;   // registered request, valid on the evaluate cycle
    ptw_pkg::t_rsp_slot rsp_slot;   // result to load into the output register
    logic               out_free;   // output register can take a new result

    // input register
    ptw_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_req      (i_in_req),
        .i_out_free (out_free),
        .o_slot     (req_slot)
    );

    // walk state and the per-request step logic
    ptw_walk_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (req_slot),
        .o_slot  (rsp_slot)
    );

    // result register
    ptw_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (rsp_slot),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_rsp   (o_out_rsp)
    );

endmodule

>>> rtl/core/ptw_checker.sv
`include "page_table_walk_and_map_defines.svh"

module ptw_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input ptw_pkg::t_req i_in_req,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ptw_pkg::t_rsp o_out_rsp
);

    logic in_held;
    logic out_held;
    logic out_read;
    logic out_write;
    logic out_miss;
    logic no_data;
    logic write_ok;

    assign in_held   = i_in_valid && o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_read  = o_out_valid && o_out_rsp.kind == ptw_pkg::KIND_READ;
    assign out_write = o_out_valid && o_out_rsp.kind == ptw_pkg::KIND_WRITE;
    assign out_miss  = o_out_valid && o_out_rsp.kind == ptw_pkg::KIND_LOOKUP_DONE
                       && !o_out_rsp.found;
    assign no_data   = o_out_rsp.write_data == '0 && o_out_rsp.leaf_entry == '0
                       && !o_out_rsp.found;
    assign write_ok  = (o_out_rsp.write_data & ptw_pkg::PTE_FLAGS) == ptw_pkg::PTE_FLAGS
                       && o_out_rsp.leaf_entry == '0;

    `PTW_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_held, i_in_valid && $stable(i_in_req))

    `PTW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_rsp))

    `PTW_ASSERT_NOW(a_read_clean, i_clk, i_rst_n, out_read, no_data)

    `PTW_ASSERT_NOW(a_write_flags, i_clk, i_rst_n, out_write, write_ok)

    `PTW_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, out_miss, o_out_rsp.leaf_entry == '0)

endmodule

bind page_table_walk_and_map ptw_checker u_ptw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Walk phases as this bench tracks them; they mirror the block's own sequencing.
    typedef enum logic [4:0] {
        PHASE_IDLE  = 5'b00001,
        PHASE_READ  = 5'b00010,
        PHASE_GRANT = 5'b00100,
        PHASE_LINK  = 5'b01000,
        PHASE_LEAF  = 5'b10000
    } t_walk_phase;

    localparam int unsigned RUN_LIMIT  = 200000;
    localparam int unsigned TAIL_WAIT  = 8;
    localparam int          NOISE_PCT  = 12;

    // ------------------------------------------------------------------
    // Walk predictor and store of expected results.
    // note_request() advances the predicted walk by one accepted request and
    // queues the result it causes; check_result() compares one result with
    // the oldest queued one.
    // ------------------------------------------------------------------
    class t_walk_scoreboard;
        t_walk_phase   phase;
        logic [1:0]    level;
        logic [47:0]   held_va;
        logic [63:0]   table_base;
        logic [63:0]   next_frame;
        logic [9:0]    pages_left;
        logic [9:0]    leaf_cursor;
        logic          mapping;
        ptw_pkg::t_rsp expected_q[$];
        int            errors;

        function new();
            phase       = PHASE_IDLE;
            level       = '0;
            held_va     = '0;
            table_base  = '0;
            next_frame  = '0;
            pages_left  = '0;
            leaf_cursor = '0;
            mapping     = 1'b0;
            errors      = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // 9-bit index of the held address at a walk level: bits 47:39 down to 20:12
        function logic [8:0] index_at(int lv);
            return 9'(held_va >> (39 - 9 * lv));
        endfunction

        function logic [63:0] entry_addr(int lv);
            return table_base + (64'(index_at(lv)) << 3);
        endfunction

        function void emit(logic [2:0] kind, logic [63:0] addr, logic [63:0] data,
                           logic [63:0] leaf, logic fnd);
            ptw_pkg::t_rsp rsp;
            rsp.kind        = kind;
            rsp.mem_address = addr;
            rsp.write_data  = data;
            rsp.leaf_entry  = leaf;
            rsp.found       = fnd;
            expected_q.push_back(rsp);
        endfunction

        // next leaf write, or map done once the count is used up
        function void leaf_next();
            if (pages_left == '0) begin
                phase = PHASE_IDLE;
                emit(ptw_pkg::KIND_MAP_DONE, 64'd0, 64'd0, 64'd0, 1'b1);
            end else begin
                emit(ptw_pkg::KIND_WRITE, table_base + (64'(leaf_cursor) << 3),
                     next_frame | ptw_pkg::PTE_FLAGS, 64'd0, 1'b0);
                next_frame  = next_frame + ptw_pkg::PAGE_STEP;
                leaf_cursor = leaf_cursor + 10'd1;
                pages_left  = pages_left - 10'd1;
                phase       = PHASE_LEAF;
            end
        endfunction

        // leaf run must stay inside one table
        function void leaf_start();
            if (int'(index_at(3)) + int'(pages_left) > ptw_pkg::ENTRIES_PER_TABLE) begin
                phase = PHASE_IDLE;
                emit(ptw_pkg::KIND_MAP_DONE, 64'd0, 64'd0, 64'd0, 1'b0);
            end else begin
                leaf_cursor = 10'(index_at(3));
                leaf_next();
            end
        endfunction

        function bit note_request(ptw_pkg::t_req r);
            int queued;
            queued = expected_q.size();
            if ((r.operation == ptw_pkg::OP_LOOKUP || r.operation == ptw_pkg::OP_MAP) &&
                phase == PHASE_IDLE) begin
                held_va    = r.virt_addr;
                table_base = 64'(r.root_base);
                level      = '0;
                mapping    = (r.operation == ptw_pkg::OP_MAP);
                if (mapping) begin
                    next_frame = 64'(r.first_frame);
                    pages_left = r.page_count;
                end
                phase = PHASE_READ;
                emit(ptw_pkg::KIND_READ, entry_addr(0), 64'd0, 64'd0, 1'b0);
            end else if (r.operation == ptw_pkg::OP_READ_DATA && phase == PHASE_READ) begin
                if (level == ptw_pkg::LEVEL_LEAF) begin
                    // leaf goes back as read, present bit not checked
                    phase = PHASE_IDLE;
                    emit(ptw_pkg::KIND_LOOKUP_DONE, 64'd0, 64'd0, r.read_data, 1'b1);
                end else if (r.read_data[0]) begin
                    table_base = r.read_data & ptw_pkg::ENTRY_MASK;
                    level      = level + 2'd1;
                    if (mapping && level == ptw_pkg::LEVEL_LEAF)
                        leaf_start();
                    else
                        emit(ptw_pkg::KIND_READ, entry_addr(level), 64'd0, 64'd0, 1'b0);
                end else if (!mapping) begin
                    phase = PHASE_IDLE;
                    emit(ptw_pkg::KIND_LOOKUP_DONE, 64'd0, 64'd0, 64'd0, 1'b0);
                end else begin
                    phase = PHASE_GRANT;
                    emit(ptw_pkg::KIND_ALLOC, 64'd0, 64'd0, 64'd0, 1'b0);
                end
            end else if (r.operation == ptw_pkg::OP_GRANT && phase == PHASE_GRANT) begin
                emit(ptw_pkg::KIND_WRITE, entry_addr(level),
                     64'(r.granted_page) | ptw_pkg::PTE_FLAGS, 64'd0, 1'b0);
                table_base = 64'(r.granted_page);
                level      = level + 2'd1;
                phase      = PHASE_LINK;
            end else if (r.operation == ptw_pkg::OP_WRITE_DONE && phase == PHASE_LINK) begin
                if (level == ptw_pkg::LEVEL_LEAF) begin
                    leaf_start();
                end else begin
                    phase = PHASE_GRANT;
                    emit(ptw_pkg::KIND_ALLOC, 64'd0, 64'd0, 64'd0, 1'b0);
                end
            end else if (r.operation == ptw_pkg::OP_WRITE_DONE && phase == PHASE_LEAF) begin
                leaf_next();
            end
            return expected_q.size() > queued;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(ptw_pkg::t_rsp got);
            ptw_pkg::t_rsp want;
            if (expected_q.size() == 0) begin
                $error("result with none expected: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("write_data", want.write_data, got.write_data);
            check_field("leaf_entry", want.leaf_entry, got.leaf_entry);
            check_field("found", 64'(want.found), 64'(got.found));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    ptw_pkg::t_req i_in_req    = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    ptw_pkg::t_rsp o_out_rsp;

    page_table_walk_and_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    t_walk_scoreboard sb = new();

    // Idle and stall rates, in percent; changed between stimulus phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int unsigned cycle_count = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop: a hung walk or a lost result ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: check what is taken at this edge, then pick the next stall.
    // Values read here are the ones from before the edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
                sb.check_result(o_out_rsp);
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // All fields random; the caller pins what matters for the walk.
    function automatic ptw_pkg::t_req rand_req(logic [2:0] op);
        ptw_pkg::t_req r;
        r.operation    = op;
        r.virt_addr    = 48'({$urandom(), $urandom()});
        r.root_base    = 52'({$urandom(), $urandom()});
        r.first_frame  = 52'({$urandom(), $urandom()});
        r.page_count   = 10'($urandom_range(512));
        r.read_data    = {$urandom(), $urandom()};
        r.granted_page = 52'({$urandom(), $urandom()});
        return r;
    endfunction

    // Mostly the request the walk is waiting for, so walks run to the end;
    // the rest is noise of any opcode, including the unused ones.
    function automatic ptw_pkg::t_req next_request();
        ptw_pkg::t_req r;
        logic [9:0]    n;
        if ($urandom_range(99) < NOISE_PCT)
            return rand_req(3'($urandom_range(7)));
        case (sb.phase)
            PHASE_IDLE: begin
                r = rand_req($urandom_range(1) ? ptw_pkg::OP_MAP : ptw_pkg::OP_LOOKUP);
                case ($urandom_range(9))
                    0: n = 10'd0;
                    1: n = 10'd512;
                    2, 3: begin
                        // leaf run that just fits or overruns by one
                        n = 10'($urandom_range(8, 2));
                        r.virt_addr[20:12] = 9'(512 - int'(n) + int'($urandom_range(1)));
                    end
                    default: n = 10'($urandom_range(6, 1));
                endcase
                r.page_count = n;
            end
            PHASE_READ: begin
                r = rand_req(ptw_pkg::OP_READ_DATA);
                r.read_data[0] = ($urandom_range(99) < 75);
            end
            PHASE_GRANT: r = rand_req(ptw_pkg::OP_GRANT);
            default:     r = rand_req(ptw_pkg::OP_WRITE_DONE);
        endcase
        return r;
    endfunction

    // Hold the request until taken, then note it. Valid stays up on return so
    // back-to-back requests never drop it for a step.
    task automatic send_request(input ptw_pkg::t_req r, output bit made);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        made = sb.note_request(r);
    endtask

    task automatic pause_cycle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending until every expected result has come back.
    task automatic drain();
        pause_cycle();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(int idle_pct, int stall_pct, int target);
        ptw_pkg::t_req r;
        bit            made;
        int            sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent           = 0;
        while (sent < target) begin
            while ($urandom_range(99) < send_idle_pct)
                pause_cycle();
            if ($urandom_range(149) == 0)
                drain();
            r = next_request();
            send_request(r, made);
            sent++;
        end
    endtask

    initial begin
        ptw_pkg::t_req r;
        bit            made;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: full lookup at the top of both spaces; the all-ones
        // entries read back make the lower-level entry addresses wrap past 2^64
        r = rand_req(ptw_pkg::OP_LOOKUP);
        r.virt_addr = '1;
        r.root_base = '1;
        send_request(r, made);
        repeat (3) begin
            r = rand_req(ptw_pkg::OP_READ_DATA);
            r.read_data = '1;
            send_request(r, made);
        end
        // leaf not present still comes back as read, with found set
        r = rand_req(ptw_pkg::OP_READ_DATA);
        r.read_data = 64'hFFFF_FFFF_FFFF_FFFE;
        send_request(r, made);

        // --- map of zero pages through present tables at address zero
        r = rand_req(ptw_pkg::OP_MAP);
        r.virt_addr  = '0;
        r.root_base  = '0;
        r.page_count = 10'd0;
        send_request(r, made);
        repeat (3) begin
            r = rand_req(ptw_pkg::OP_READ_DATA);
            r.read_data = 64'd1;
            send_request(r, made);
        end

        // --- map that does not fit (full count from leaf index 1), with
        // requests that must be dropped while the walk is busy
        r = rand_req(ptw_pkg::OP_MAP);
        r.virt_addr[20:12] = 9'd1;
        r.page_count       = 10'd512;
        send_request(r, made);
        send_request(rand_req(ptw_pkg::OP_LOOKUP), made);
        send_request(rand_req(3'd7), made);
        send_request(rand_req(ptw_pkg::OP_WRITE_DONE), made);
        repeat (3) begin
            r = rand_req(ptw_pkg::OP_READ_DATA);
            r.read_data[0] = 1'b1;
            send_request(r, made);
        end

        // --- map with level 1 missing: two tables allocated and linked, a
        // stray grant dropped, then two leaves ending at the table's last entry
        r = rand_req(ptw_pkg::OP_MAP);
        r.virt_addr[20:12] = 9'd510;
        r.first_frame      = '1;
        r.page_count       = 10'd2;
        send_request(r, made);
        r = rand_req(ptw_pkg::OP_READ_DATA);
        r.read_data[0] = 1'b1;
        send_request(r, made);
        r = rand_req(ptw_pkg::OP_READ_DATA);
        r.read_data = 64'hFFFF_FFFF_FFFF_FFFE;
        send_request(r, made);
        r = rand_req(ptw_pkg::OP_GRANT);
        r.granted_page = '1;  // low flag bits already set, kept as given
        send_request(r, made);
        send_request(rand_req(ptw_pkg::OP_WRITE_DONE), made);
        r = rand_req(ptw_pkg::OP_GRANT);
        r.granted_page = '0;
        send_request(r, made);
        send_request(rand_req(ptw_pkg::OP_WRITE_DONE), made);
        send_request(rand_req(ptw_pkg::OP_GRANT), made);
        repeat (3)
            send_request(rand_req(ptw_pkg::OP_WRITE_DONE), made);
        drain();

        // --- random: slow receiver, then slow sender, then full rate
        run_random(7, 85, 367);
        run_random(85, 7, 367);
        drain();
        run_random(0, 0, 366);

        // wait out every expected result, then watch for strays
        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ptw_pkg.sv
rtl/core/ptw_in_stage.sv
rtl/core/ptw_walk_core.sv
rtl/core/ptw_out_stage.sv
rtl/core/page_table_walk_and_map.sv
rtl/core/ptw_checker.sv
sim/testbench.sv
